// ===== hw/rtl/vumlt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vumlt_pkg;

  localparam int unsigned NUM_SEGMENTS = 8;

  localparam logic [7:0]  SILENCE_LEVEL = 8'h80;
  localparam logic [7:0]  LEVEL_MAX     = 8'hFF;

  // Register reset values
  localparam logic [7:0]  HOLD_FRAMES_RST     = 8'd3;
  localparam logic [3:0]  DECAY_STEP_RST      = 4'd1;
  localparam logic [31:0] THRESHOLDS_LOW_RST  = 32'h2F1A_0B02; // 2, 11, 26, 47
  localparam logic [31:0] THRESHOLDS_HIGH_RST = 32'hFAAF_764D; // 77, 118, 175, 250

  typedef enum logic [7:0] {
    REG_HOLD_FRAMES     = 8'd0,
    REG_DECAY_STEP      = 8'd1,
    REG_THRESHOLDS_LOW  = 8'd2,
    REG_THRESHOLDS_HIGH = 8'd3
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  hold_frames;
    logic [3:0]  decay_step;
    logic [31:0] thresholds_low;
    logic [31:0] thresholds_high;
  } cfg_t;

  // One item held in the input register
  typedef struct packed {
    logic [7:0] level;
    logic       frame_end;
  } item_t;

  // Twice |s - 128|, saturated to 255
  function automatic logic [7:0] level_of(input logic [7:0] s);
    logic [7:0] mag;
    logic [8:0] twice;
    begin
      mag   = (s >= SILENCE_LEVEL) ? (s - SILENCE_LEVEL) : (SILENCE_LEVEL - s);
      twice = {mag, 1'b0};
      level_of = twice[8] ? LEVEL_MAX : twice[7:0];
    end
  endfunction

  function automatic logic [7:0] threshold_of(input cfg_t cfg, input logic [2:0] seg);
    logic [63:0] all;
    begin
      all = {cfg.thresholds_high, cfg.thresholds_low};
      threshold_of = all[{seg, 3'b000} +: 8];
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vumlt_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vumlt_cfg_regs
  import vumlt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_HOLD_FRAMES:     cfg_d.hold_frames     = cfg_data_i[7:0];
        REG_DECAY_STEP:      cfg_d.decay_step      = cfg_data_i[3:0];
        REG_THRESHOLDS_LOW:  cfg_d.thresholds_low  = cfg_data_i;
        REG_THRESHOLDS_HIGH: cfg_d.thresholds_high = cfg_data_i;
        default:             cfg_d = cfg_q; // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_frames     <= HOLD_FRAMES_RST;
      cfg_q.decay_step      <= DECAY_STEP_RST;
      cfg_q.thresholds_low  <= THRESHOLDS_LOW_RST;
      cfg_q.thresholds_high <= THRESHOLDS_HIGH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/vumlt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vumlt_front
  import vumlt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] sample_i,
  input  wire logic       frame_end_i,
  output logic            s1_valid_o,
  output item_t           s1_item_o,
  input  wire logic       s1_ready_i
);

  logic  s1_valid_q, s1_valid_d;
  item_t s1_item_q;
  logic  load;

  assign in_stall_o = s1_valid_q && !s1_ready_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    priority if (load) begin
      s1_valid_d = 1'b1;
    end else if (s1_ready_i) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Level is formed on the way in
  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_item_q.level     <= level_of(sample_i);
      s1_item_q.frame_end <= frame_end_i;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_item_o  = s1_item_q;

endmodule

`default_nettype wire

// ===== hw/rtl/vumlt_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vumlt_eval
  import vumlt_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  s1_valid_i,
  input  wire item_t s1_item_i,
  output logic       s1_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output logic [3:0] lit_segments_o,
  output logic       refreshed_o
);

  logic [7:0] peak_q, peak_d;
  logic [7:0] frame_cnt_q, frame_cnt_d;
  logic [3:0] lit_q, lit_d;
  logic       out_valid_q, out_valid_d;
  logic [3:0] lit_seg_q;
  logic       refreshed_q;

  logic       fire, load_out, do_eval;
  logic [7:0] peak_now;
  logic [3:0] segs;
  logic       run;

  // Items without frame end make no transaction, so they never wait
  assign s1_ready_o = !s1_item_i.frame_end || !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_i && s1_ready_o;
  assign load_out   = fire && s1_item_i.frame_end;
  assign peak_now   = (s1_item_i.level > peak_q) ? s1_item_i.level : peak_q;
  assign do_eval    = load_out && (frame_cnt_q == cfg_i.hold_frames);

  // Segments met in order, stop at first miss
  always_comb begin
    segs = '0;
    run  = 1'b1;
    for (int unsigned i = 0; i < NUM_SEGMENTS; i++) begin
      if (run && (peak_now >= threshold_of(cfg_i, 3'(i)))) begin
        segs = segs + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
  end

  always_comb begin
    peak_d      = peak_q;
    frame_cnt_d = frame_cnt_q;
    lit_d       = lit_q;
    if (fire) begin
      peak_d = peak_now;
    end
    if (load_out) begin
      if (do_eval) begin
        peak_d      = '0;
        frame_cnt_d = '0;
        if (segs > lit_q) begin
          lit_d = segs;
        end else if (lit_q > cfg_i.decay_step) begin
          lit_d = lit_q - cfg_i.decay_step;
        end else begin
          lit_d = '0;
        end
      end else begin
        frame_cnt_d = frame_cnt_q + 8'd1;
      end
    end
  end

  always_comb begin
    priority if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q      <= '0;
      frame_cnt_q <= '0;
      lit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      peak_q      <= peak_d;
      frame_cnt_q <= frame_cnt_d;
      lit_q       <= lit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      lit_seg_q   <= lit_d;
      refreshed_q <= do_eval;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign lit_segments_o = lit_seg_q;
  assign refreshed_o    = refreshed_q;

  a_lit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lit_q <= 4'(NUM_SEGMENTS))
    else $error("lit count above segment count");

  a_refresh_clears_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && refreshed_q) |-> (frame_cnt_q == 8'd0))
    else $error("frame count not cleared after evaluation");

  a_hold_shows_lit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !refreshed_q) |-> (lit_seg_q == lit_q))
    else $error("non-evaluating result does not match lit count");

  a_no_fire_without_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(lit_seg_q)))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== hw/rtl/vu_meter_level_tracker_core.sv =====
// Peak meter with stepped decay.
// Input channel (in_valid_i / in_stall_o): one 8-bit offset-binary sample per
// transaction, with frame_end_i marking the last sample of a frame. The peak of
// twice |sample - 128| (saturated to 255) is tracked. Every hold_frames+1
// frame ends the peak is graded against eight ascending thresholds; a higher
// segment count is taken at once, otherwise the lit count decays by
// decay_step, floored at 0. The peak is then cleared.
// Output channel (out_valid_o / out_stall_i): one transaction per frame-end
// sample carrying lit_segments_o and refreshed_o; other samples give none.
// Config channel (cfg_valid_i / cfg_ready_o): always ready; write only when
// the block is idle.
// A sample passes the input register, then the result register. Throughput:
// one sample per cycle unless a frame-end sample waits on a stalled result,
// set by the single evaluation stage between the two registers.
// Stalls: a result held by out_stall_i holds the next frame-end sample in the
// input register, which then stalls the input; plain samples ahead of it keep
// flowing into the peak.
// Reset: registers return to their defaults, peak, frame count and lit count
// clear, both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none

module vu_meter_level_tracker_core
  import vumlt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  sample_i,
  input  wire logic        frame_end_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       lit_segments_o,
  output logic             refreshed_o,
  // config channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  cfg_t  cfg;
  logic  s1_valid;
  item_t s1_item;
  logic  s1_ready;

  vumlt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Input register: holds the level of one sample
  vumlt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .frame_end_i (frame_end_i),
    .s1_valid_o  (s1_valid),
    .s1_item_o   (s1_item),
    .s1_ready_i  (s1_ready)
  );

  // Peak, grading, decay and result register
  vumlt_eval u_eval (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .s1_valid_i     (s1_valid),
    .s1_item_i      (s1_item),
    .s1_ready_o     (s1_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .lit_segments_o (lit_segments_o),
    .refreshed_o    (refreshed_o)
  );

endmodule

`default_nettype wire
